/* rtl/best_fit_block_cache_top_defines.svh */
// Assertion macros used by the block cache top.
`ifndef BEST_FIT_BLOCK_CACHE_TOP_DEFINES_SVH
`define BEST_FIT_BLOCK_CACHE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define BFC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define BFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bfc_pkg.sv */
package bfc_pkg;

    localparam int DATA_W  = 32;
    localparam int COUNT_W = 4;

    // Request actions
    localparam logic ACT_TAKE = 1'b0;
    localparam logic ACT_GIVE = 1'b1;

    typedef struct packed {
        logic              action;
        logic [DATA_W-1:0] block_size;
        logic [DATA_W-1:0] block_handle;
    } bfc_req_t;

    typedef struct packed {
        logic               hit;
        logic [DATA_W-1:0]  out_handle;
        logic               evicted;
        logic [COUNT_W-1:0] entry_count;
    } bfc_rsp_t;

    // Outcome of the shared size comparator
    typedef struct packed {
        logic ge;
        logic gt;
    } cmp_res_t;

endpackage

/* rtl/bfc_req_if.sv */
interface bfc_req_if;
    import bfc_pkg::*;

    logic     valid;
    logic     ready;
    bfc_req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/bfc_rsp_if.sv */
interface bfc_rsp_if;
    import bfc_pkg::*;

    logic     valid;
    logic     ready;
    bfc_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/bfc_ram.sv */
module bfc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one word, register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/bfc_cmp.sv */
module bfc_cmp (
    input  logic [bfc_pkg::DATA_W-1:0] a,
    input  logic [bfc_pkg::DATA_W-1:0] b,
    output bfc_pkg::cmp_res_t          res
);
    import bfc_pkg::*;

    logic [DATA_W:0] diff;

    // Subtract once, derive both orderings from borrow and zero
    assign diff   = {1'b0, a} - {1'b0, b};
    assign res.ge = ~diff[DATA_W];
    assign res.gt = ~diff[DATA_W] & (diff[DATA_W-1:0] != '0);

endmodule

/* rtl/best_fit_block_cache_top.sv */
// Result: each item ends in the finish state, which waits there while a previous result
// is still held at the output.
// Throughput: one item at a time; the single RAM and the one comparator
// step through one cached entry per cycle for the search and for the shift.
// Reset: asynchronous, clears the sequencer, the entry count and the output valid;
// entry storage is not cleared and needs no clearing pass.
`include "best_fit_block_cache_top_defines.svh"

module best_fit_block_cache_top #(
    parameter int CACHE_ENTRIES = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    bfc_req_if.sink    req,
    bfc_rsp_if.source  rsp
);
    import bfc_pkg::*;

    localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int ENT_W = 2 * DATA_W;

    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CACHE_ENTRIES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CACHE_ENTRIES - 1);

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_SHDN  = 3'd2;
    localparam logic [2:0] ST_SHUP  = 3'd3;
    localparam logic [2:0] ST_WRNEW = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic              act_reg, act_next;
    logic [DATA_W-1:0] sz_reg, sz_next;
    logic [DATA_W-1:0] hd_reg, hd_next;
    logic              hit_reg, hit_next;
    logic [DATA_W-1:0] oh_reg, oh_next;
    logic              ev_reg, ev_next;
    logic              out_valid_reg, out_valid_next;
    bfc_rsp_t          out_data_reg, out_data_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [ENT_W-1:0]  ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [ENT_W-1:0]  ram_rdata;
    logic [DATA_W-1:0] rd_size;
    logic [DATA_W-1:0] rd_handle;
    cmp_res_t          cmp_res;

    logic [CNT_W-1:0]  count_m1;
    logic [CNT_W-1:0]  idx_p1;
    logic [CNT_W-1:0]  idx_p2;
    logic [CNT_W-1:0]  idx_m1;
    logic [CNT_W+3:0]  count_ext;
    logic              full;
    logic              match;
    logic              last;

    // Entry storage: {size, handle} per slot, kept in ascending size order
    bfc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CACHE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_size   = ram_rdata[ENT_W-1:DATA_W];
    assign rd_handle = ram_rdata[DATA_W-1:0];

    // Shared comparator: entry size against the item's size
    bfc_cmp u_cmp (
        .a   (rd_size),
        .b   (sz_reg),
        .res (cmp_res)
    );

    assign count_m1  = count_reg - CNT_ONE;
    assign idx_p1    = idx_reg + CNT_ONE;
    assign idx_p2    = idx_reg + CNT_W'(2);
    assign idx_m1    = idx_reg - CNT_ONE;
    assign count_ext = {4'b0000, count_reg};
    assign full      = (count_reg == CNT_FULL);
    assign match     = (act_reg == ACT_TAKE) ? cmp_res.ge : cmp_res.gt;
    assign last      = (idx_reg == count_m1);

    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        act_next       = act_reg;
        sz_next        = sz_reg;
        hd_next        = hd_reg;
        hit_next       = hit_reg;
        oh_next        = oh_reg;
        ev_next        = ev_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg[IDX_W-1:0];
        ram_wdata      = ram_rdata;
        ram_raddr      = '0;

        // Drop the result once taken
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    act_next  = req.data.action;
                    sz_next   = req.data.block_size;
                    hd_next   = req.data.block_handle;
                    hit_next  = 1'b0;
                    oh_next   = '0;
                    ev_next   = 1'b0;
                    idx_next  = '0;
                    ram_raddr = '0;
                    if (req.data.action == ACT_GIVE && req.data.block_handle == '0)
                    begin
                        state_next = ST_FIN;
                    end
                    else if (count_reg == '0)
                    begin
                        pos_next   = '0;
                        state_next = (req.data.action == ACT_TAKE) ? ST_FIN : ST_WRNEW;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            // Walk entries from the smallest, one compare per cycle
            ST_SCAN:
            begin
                if (act_reg == ACT_TAKE)
                begin
                    if (match)
                    begin
                        hit_next = 1'b1;
                        oh_next  = rd_handle;
                        if (last)
                        begin
                            count_next = count_m1;
                            state_next = ST_FIN;
                        end
                        else
                        begin
                            ram_raddr  = idx_p1[IDX_W-1:0];
                            state_next = ST_SHDN;
                        end
                    end
                    else if (last)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        idx_next  = idx_p1;
                        ram_raddr = idx_p1[IDX_W-1:0];
                    end
                end
                else
                begin
                    if (match)
                    begin
                        pos_next   = idx_reg;
                        idx_next   = count_m1;
                        ram_raddr  = count_m1[IDX_W-1:0];
                        state_next = ST_SHUP;
                    end
                    else if (last)
                    begin
                        // New block is the largest
                        pos_next = count_reg;
                        if (full)
                        begin
                            ev_next    = 1'b1;
                            oh_next    = hd_reg;
                            state_next = ST_FIN;
                        end
                        else
                        begin
                            state_next = ST_WRNEW;
                        end
                    end
                    else
                    begin
                        idx_next  = idx_p1;
                        ram_raddr = idx_p1[IDX_W-1:0];
                    end
                end
            end

            // Close the gap: entry idx+1 arrives, write it at idx
            ST_SHDN:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[IDX_W-1:0];
                ram_wdata = ram_rdata;
                if (idx_p1 == count_m1)
                begin
                    count_next = count_m1;
                    state_next = ST_FIN;
                end
                else
                begin
                    idx_next  = idx_p1;
                    ram_raddr = idx_p2[IDX_W-1:0];
                end
            end

            // Open a slot: entry idx arrives, move it to idx+1 or evict it
            ST_SHUP:
            begin
                if (idx_reg == CNT_LAST)
                begin
                    ev_next = 1'b1;
                    oh_next = rd_handle;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_p1[IDX_W-1:0];
                    ram_wdata = ram_rdata;
                end
                if (idx_reg == pos_reg)
                begin
                    state_next = ST_WRNEW;
                end
                else
                begin
                    idx_next  = idx_m1;
                    ram_raddr = idx_m1[IDX_W-1:0];
                end
            end

            // Place the returned block at its slot
            ST_WRNEW:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg[IDX_W-1:0];
                ram_wdata = {sz_reg, hd_reg};
                if (!full)
                begin
                    count_next = count_reg + CNT_ONE;
                end
                state_next = ST_FIN;
            end

            // Hand the result to the output register when it is free
            ST_FIN:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.hit         = hit_reg;
                    out_data_next.out_handle  = oh_reg;
                    out_data_next.evicted     = ev_reg;
                    out_data_next.entry_count = count_ext[COUNT_W-1:0];
                    state_next                = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        act_reg      <= act_next;
        sz_reg       <= sz_next;
        hd_reg       <= hd_next;
        hit_reg      <= hit_next;
        oh_reg       <= oh_next;
        ev_reg       <= ev_next;
        out_data_reg <= out_data_next;
    end

    `BFC_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_FULL,
        "entry count exceeds capacity")
    `BFC_ASSERT_NEXT(a_accept_busy, clk, rst_n, req.valid && req.ready,
        state_reg != ST_IDLE, "item finished in the cycle it was accepted")
    `BFC_ASSERT_NOW(a_shdn_count, clk, rst_n, state_reg == ST_SHDN,
        count_reg >= CNT_W'(2), "shift down with fewer than two entries")
    `BFC_ASSERT_NOW(a_evict_full, clk, rst_n, state_reg == ST_FIN && ev_reg,
        full && !hit_reg && act_reg == ACT_GIVE, "eviction without a full cache")

endmodule
